@@ design/mqts_pkg.sv @@
// package for the min queue built from two stacks
// holds depth, widths, opcode and status codes, the stack entry type and the signed minimum
// no dependencies
`default_nettype none
package mqts_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	localparam logic [2:0] OP_ENQ   = 3'd0;
	localparam logic [2:0] OP_DEQ   = 3'd1;
	localparam logic [2:0] OP_FRONT = 3'd2;
	localparam logic [2:0] OP_SIZE  = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;
	localparam logic [2:0] OP_MIN   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_VALUE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic signed [31:0] run_min;
		logic signed [31:0] value;
	} entry_t;

	function automatic logic signed [31:0] smin(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage
`default_nettype wire

@@ design/mqts_if.sv @@
// valid/ready channels for command words and result words
// depends on nothing
`default_nettype none
interface mqts_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic signed [31:0] value_in;

	modport source (output valid, output opcode, output value_in, input ready);
	modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

interface mqts_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] value_out;

	modport source (output valid, output status, output value_out, input ready);
	modport sink   (input valid, input status, input value_out, output ready);
endinterface
`default_nettype wire

@@ design/mqts_ram.sv @@
// generic simple dual port ram, one write port and one registered read port
// depends on nothing
`default_nettype none
module mqts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ design/min_queue_two_stack.sv @@
// A FIFO of signed 32-bit words that also reports its minimum, kept as an inbound and an
// outbound stack in two RAMs whose entries carry a value and the running minimum. One command
// word is taken at a time and gives one result word, registered in the output register when
// the command executes. A dequeue that leaves at least one outbound entry then reads the new
// outbound top in a refresh state before the next command is taken. When front or dequeue finds
// the outbound stack empty, all N inbound entries are moved first at one entry per cycle, set
// by the single read port of the inbound RAM. A result word not yet taken holds the next
// command in execution until the output register frees. No clearing pass is needed after
// reset.
// depends on mqts_pkg, mqts_if and mqts_ram
`default_nettype none
module min_queue_two_stack (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mqts_cmd_if.sink   cmd,
	mqts_rsp_if.source rsp
);

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_EXEC    = 2'd1;
	localparam logic [1:0] S_XFER    = 2'd2;
	localparam logic [1:0] S_REFRESH = 2'd3;

	logic [1:0]             state_q;
	logic [mqts_pkg::CW-1:0] in_cnt_q, out_cnt_q, total, in_cnt_m1, out_cnt_m1, out_cnt_m2;
	logic [2:0]             op_q;
	logic signed [31:0]     val_q;
	logic signed [31:0]     in_min_q;
	mqts_pkg::entry_t       out_top_q;
	logic                   rsp_valid_q;
	logic [1:0]             rsp_status_q;
	logic signed [31:0]     rsp_value_q;

	logic                   in_we, in_re, out_we, out_re;
	mqts_pkg::entry_t       in_wdata, out_wdata, in_rdata, out_rdata;
	logic signed [31:0]     enq_min;
	logic                   full, empty, start_xfer, exec_done, slot_free;
	logic [1:0]             exec_status;
	logic signed [31:0]     exec_value;

	assign total      = in_cnt_q + out_cnt_q;
	assign in_cnt_m1  = in_cnt_q - mqts_pkg::CW'(1);
	assign out_cnt_m1 = out_cnt_q - mqts_pkg::CW'(1);
	assign out_cnt_m2 = out_cnt_q - mqts_pkg::CW'(2);
	assign full       = (total == mqts_pkg::CW'(mqts_pkg::DEPTH));
	assign empty      = (total == '0);
	assign slot_free  = !rsp_valid_q || rsp.ready;

	assign cmd.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.value_out = rsp_value_q;

	assign enq_min = (in_cnt_q == '0) ? val_q : mqts_pkg::smin(val_q, in_min_q);

	// decode of the held command
	always_comb begin
		exec_status = mqts_pkg::ST_OK;
		exec_value  = '0;
		start_xfer  = 1'b0;
		unique case (op_q)
			mqts_pkg::OP_ENQ: begin
				if (full) begin
					exec_status = mqts_pkg::ST_FULL;
				end
			end
			mqts_pkg::OP_DEQ, mqts_pkg::OP_FRONT: begin
				if (empty) begin
					exec_status = mqts_pkg::ST_EMPTY;
				end else if (out_cnt_q == '0) begin
					start_xfer = 1'b1;
				end else begin
					exec_status = mqts_pkg::ST_VALUE;
					exec_value  = out_top_q.value;
				end
			end
			mqts_pkg::OP_SIZE: begin
				exec_status = mqts_pkg::ST_VALUE;
				exec_value  = signed'(32'(total));
			end
			mqts_pkg::OP_MIN: begin
				priority if (empty) begin
					exec_status = mqts_pkg::ST_EMPTY;
				end else if (in_cnt_q == '0) begin
					exec_status = mqts_pkg::ST_VALUE;
					exec_value  = out_top_q.run_min;
				end else if (out_cnt_q == '0) begin
					exec_status = mqts_pkg::ST_VALUE;
					exec_value  = in_min_q;
				end else begin
					exec_status = mqts_pkg::ST_VALUE;
					exec_value  = mqts_pkg::smin(out_top_q.run_min, in_min_q);
				end
			end
			default: begin
			end
		endcase
		exec_done = (state_q == S_EXEC) && !start_xfer && slot_free;
	end

	// stack ram controls
	always_comb begin
		in_we             = exec_done && (op_q == mqts_pkg::OP_ENQ) && !full;
		in_wdata.run_min  = enq_min;
		in_wdata.value    = val_q;
		in_re             = ((state_q == S_EXEC) && start_xfer) ||
				((state_q == S_XFER) && (in_cnt_q != '0));
		out_we            = (state_q == S_XFER);
		out_wdata.value   = in_rdata.value;
		out_wdata.run_min = (out_cnt_q == '0) ? in_rdata.value :
				mqts_pkg::smin(in_rdata.value, out_top_q.run_min);
		out_re            = exec_done && (op_q == mqts_pkg::OP_DEQ) && !empty &&
				(out_cnt_q > mqts_pkg::CW'(1));
	end

	mqts_ram #(
		.WIDTH ($bits(mqts_pkg::entry_t)),
		.DEPTH (mqts_pkg::DEPTH)
	) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_cnt_q[mqts_pkg::AW-1:0]),
		.wdata (in_wdata),
		.re    (in_re),
		.raddr (in_cnt_m1[mqts_pkg::AW-1:0]),
		.rdata (in_rdata)
	);

	mqts_ram #(
		.WIDTH ($bits(mqts_pkg::entry_t)),
		.DEPTH (mqts_pkg::DEPTH)
	) u_out_ram (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_cnt_q[mqts_pkg::AW-1:0]),
		.wdata (out_wdata),
		.re    (out_re),
		.raddr (out_cnt_m2[mqts_pkg::AW-1:0]),
		.rdata (out_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_cnt_q    <= '0;
			out_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (exec_done) begin
				rsp_valid_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (start_xfer) begin
						in_cnt_q <= in_cnt_m1;
						state_q  <= S_XFER;
					end else if (exec_done) begin
						state_q <= S_IDLE;
						if (op_q == mqts_pkg::OP_ENQ && !full) begin
							in_cnt_q <= in_cnt_q + mqts_pkg::CW'(1);
						end else if (op_q == mqts_pkg::OP_DEQ && !empty) begin
							out_cnt_q <= out_cnt_m1;
							if (out_re) begin
								state_q <= S_REFRESH;
							end
						end else if (op_q == mqts_pkg::OP_CLEAR) begin
							in_cnt_q  <= '0;
							out_cnt_q <= '0;
						end
					end
				end
				S_XFER: begin
					out_cnt_q <= out_cnt_q + mqts_pkg::CW'(1);
					if (in_cnt_q != '0) begin
						in_cnt_q <= in_cnt_m1;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_REFRESH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q  <= cmd.opcode;
			val_q <= cmd.value_in;
		end
		if (in_we) begin
			in_min_q <= enq_min;
		end
		if (out_we) begin
			out_top_q <= out_wdata;
		end
		if (state_q == S_REFRESH) begin
			out_top_q <= out_rdata;
		end
		if (exec_done) begin
			rsp_status_q <= exec_status;
			rsp_value_q  <= exec_value;
		end
	end

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for min_queue_two_stack: directed table, fill to full, random words
// depends on mqts_pkg, mqts_if and the min_queue_two_stack rtl
`default_nettype none
module testbench;

	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int         N_ROWS      = 25;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
	} result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] val;
		logic        typed;
		logic [1:0]  st;
		logic [31:0] res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	mqts_cmd_if cmd_ch();
	mqts_rsp_if rsp_ch();

	min_queue_two_stack u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// queue state mirror
	logic [31:0] ib_val [mqts_pkg::DEPTH];
	logic [31:0] ib_min [mqts_pkg::DEPTH];
	logic [31:0] ob_val [mqts_pkg::DEPTH];
	logic [31:0] ob_min [mqts_pkg::DEPTH];
	int          ib_cnt;
	int          ob_cnt;

	result_t     pending_results [$];
	int          errors;
	int          burst_left;
	bit          bursty;
	int          rx_tick;
	stim_row_t   dir_rows [N_ROWS];

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("[min_queue_two_stack] ERROR");
		$finish;
	end

	function automatic logic [31:0] lesser_word(input logic [31:0] a, input logic [31:0] b);
		return ($signed(a) < $signed(b)) ? a : b;
	endfunction

	task automatic predict_word(input logic [2:0] op, input logic [31:0] v, output result_t r);
		int total;
		total    = ib_cnt + ob_cnt;
		r.status = mqts_pkg::ST_OK;
		r.value  = '0;
		case (op)
			mqts_pkg::OP_ENQ: begin
				if (total >= mqts_pkg::DEPTH) begin
					r.status = mqts_pkg::ST_FULL;
				end else begin
					ib_val[ib_cnt] = v;
					ib_min[ib_cnt] = (ib_cnt == 0) ? v : lesser_word(v, ib_min[ib_cnt - 1]);
					ib_cnt++;
				end
			end
			mqts_pkg::OP_DEQ, mqts_pkg::OP_FRONT: begin
				if (total == 0) begin
					r.status = mqts_pkg::ST_EMPTY;
				end else begin
					if (ob_cnt == 0) begin
						while (ib_cnt > 0) begin
							ib_cnt--;
							ob_val[ob_cnt] = ib_val[ib_cnt];
							ob_min[ob_cnt] = (ob_cnt == 0) ? ib_val[ib_cnt]
								: lesser_word(ib_val[ib_cnt], ob_min[ob_cnt - 1]);
							ob_cnt++;
						end
					end
					r.status = mqts_pkg::ST_VALUE;
					r.value  = ob_val[ob_cnt - 1];
					if (op == mqts_pkg::OP_DEQ) begin
						ob_cnt--;
					end
				end
			end
			mqts_pkg::OP_SIZE: begin
				r.status = mqts_pkg::ST_VALUE;
				r.value  = total;
			end
			mqts_pkg::OP_CLEAR: begin
				ib_cnt = 0;
				ob_cnt = 0;
			end
			mqts_pkg::OP_MIN: begin
				if (total == 0) begin
					r.status = mqts_pkg::ST_EMPTY;
				end else if (ib_cnt == 0) begin
					r.status = mqts_pkg::ST_VALUE;
					r.value  = ob_min[ob_cnt - 1];
				end else if (ob_cnt == 0) begin
					r.status = mqts_pkg::ST_VALUE;
					r.value  = ib_min[ib_cnt - 1];
				end else begin
					r.status = mqts_pkg::ST_VALUE;
					r.value  = lesser_word(ob_min[ob_cnt - 1], ib_min[ib_cnt - 1]);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// send one word, hold until accepted, then idle per burst pattern
	task automatic send_word(input logic [2:0] op, input logic [31:0] v, input logic typed,
			input logic [1:0] st, input logic [31:0] res);
		result_t r;
		int      gap;
		cmd_ch.valid    <= 1'b1;
		cmd_ch.opcode   <= op;
		cmd_ch.value_in <= v;
		do begin
			@(posedge clk);
		end while (!cmd_ch.ready);
		predict_word(op, v, r);
		if (typed) begin
			r.status = st;
			r.value  = res;
		end
		pending_results.push_back(r);
		if (bursty) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					cmd_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_results.size() != 0);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return mqts_pkg::OP_ENQ;
		if (roll < 60) return mqts_pkg::OP_DEQ;
		if (roll < 70) return mqts_pkg::OP_FRONT;
		if (roll < 78) return mqts_pkg::OP_SIZE;
		if (roll < 93) return mqts_pkg::OP_MIN;
		if (roll < 95) return mqts_pkg::OP_CLEAR;
		if (roll < 98) return OP_SPARE_LO;
		return OP_SPARE_HI;
	endfunction

	// receiver stall pattern: cycles through four modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_tick      <= 0;
		end else begin
			rx_tick <= rx_tick + 1;
			case ((rx_tick / 97) % 4)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= $urandom_range(0, 1);
				2: rsp_ch.ready <= (rx_tick % 4) == 0;
				default: rsp_ch.ready <= $urandom_range(0, 7) != 0;
			endcase
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 32'(rsp_ch.status), rsp_ch.value_out);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
				end
				if (rsp_ch.value_out !== want.value) begin
					report_mismatch("value_out", rsp_ch.value_out, want.value);
				end
			end
		end
	end

	initial begin
		logic [2:0] op;
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.opcode   = mqts_pkg::OP_SIZE;
		cmd_ch.value_in = '0;
		errors          = 0;
		ib_cnt          = 0;
		ob_cnt          = 0;
		burst_left      = 0;
		bursty          = 1'b1;

		dir_rows = '{
			'{mqts_pkg::OP_SIZE,  32'd0,         1'b1, mqts_pkg::ST_VALUE, 32'd0},
			'{mqts_pkg::OP_DEQ,   32'd0,         1'b1, mqts_pkg::ST_EMPTY, 32'd0},
			'{mqts_pkg::OP_FRONT, 32'd0,         1'b1, mqts_pkg::ST_EMPTY, 32'd0},
			'{mqts_pkg::OP_MIN,   32'd0,         1'b1, mqts_pkg::ST_EMPTY, 32'd0},
			'{mqts_pkg::OP_ENQ,   32'h7fff_ffff, 1'b1, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_ENQ,   32'h8000_0000, 1'b1, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_ENQ,   32'd0,         1'b1, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_ENQ,   32'hffff_ffff, 1'b1, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_MIN,   32'hffff_ffff, 1'b0, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_SIZE,  32'd0,         1'b1, mqts_pkg::ST_VALUE, 32'd4},
			'{mqts_pkg::OP_FRONT, 32'hffff_ffff, 1'b0, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_DEQ,   32'd0,         1'b0, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_ENQ,   32'd5,         1'b1, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_MIN,   32'd0,         1'b0, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_DEQ,   32'd0,         1'b0, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_DEQ,   32'd0,         1'b0, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_DEQ,   32'd0,         1'b0, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_MIN,   32'd0,         1'b0, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_DEQ,   32'd0,         1'b0, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_DEQ,   32'd0,         1'b1, mqts_pkg::ST_EMPTY, 32'd0},
			'{OP_SPARE_LO,        32'hffff_ffff, 1'b1, mqts_pkg::ST_OK,    32'd0},
			'{OP_SPARE_HI,        32'd0,         1'b1, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_ENQ,   32'd123,       1'b1, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_CLEAR, 32'd0,         1'b1, mqts_pkg::ST_OK,    32'd0},
			'{mqts_pkg::OP_SIZE,  32'd0,         1'b1, mqts_pkg::ST_VALUE, 32'd0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed,
				dir_rows[i].st, dir_rows[i].res);
		end
		drain_results();

		// fill to capacity with no sender gaps, then probe full across both stacks
		bursty = 1'b0;
		for (int i = 0; i < mqts_pkg::DEPTH; i++) begin
			send_word(mqts_pkg::OP_ENQ, pick_word(), 1'b0, mqts_pkg::ST_OK, '0);
		end
		send_word(mqts_pkg::OP_ENQ, $urandom, 1'b1, mqts_pkg::ST_FULL, 32'd0);
		send_word(mqts_pkg::OP_MIN, '0, 1'b0, mqts_pkg::ST_OK, '0);
		send_word(mqts_pkg::OP_DEQ, '0, 1'b0, mqts_pkg::ST_OK, '0);
		send_word(mqts_pkg::OP_ENQ, $urandom, 1'b1, mqts_pkg::ST_OK, 32'd0);
		send_word(mqts_pkg::OP_ENQ, $urandom, 1'b1, mqts_pkg::ST_FULL, 32'd0);
		send_word(mqts_pkg::OP_SIZE, '0, 1'b1, mqts_pkg::ST_VALUE, 32'(mqts_pkg::DEPTH));
		send_word(mqts_pkg::OP_MIN, '0, 1'b0, mqts_pkg::ST_OK, '0);
		for (int i = 0; i < 5; i++) begin
			send_word(mqts_pkg::OP_DEQ, '0, 1'b0, mqts_pkg::ST_OK, '0);
		end
		send_word(mqts_pkg::OP_FRONT, '0, 1'b0, mqts_pkg::ST_OK, '0);
		send_word(mqts_pkg::OP_CLEAR, '0, 1'b1, mqts_pkg::ST_OK, 32'd0);
		drain_results();

		bursty = 1'b1;
		for (int i = 0; i < 500; i++) begin
			op = pick_op();
			send_word(op, (op == mqts_pkg::OP_ENQ) ? pick_word() : 32'($urandom), 1'b0,
				mqts_pkg::ST_OK, '0);
			if (i == 250) begin
				drain_results();
			end
		end
		cmd_ch.valid <= 1'b0;

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("[min_queue_two_stack] OK");
		end else begin
			$display("[min_queue_two_stack] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
design/mqts_pkg.sv
design/mqts_if.sv
design/mqts_ram.sv
design/min_queue_two_stack.sv
verif/testbench.sv
